### design/dtq_pkg.sv
`default_nettype none

package dtq_pkg;

  // Sizing
  localparam int CAPACITY   = 16;
  localparam int DELAY_BITS = 16;
  localparam int EVENT_BITS = 8;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int OCC_W      = $clog2(CAPACITY + 1);

  // Request opcodes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  // Response kinds
  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_EXPIRED = 2'd2
  } kind_e;

  // Cell operation broadcast from the controller
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DEC,
    CELL_SHIFT
  } cell_mode_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_TICK,
    ST_POP
  } state_e;

  typedef struct packed {
    op_e                   op;
    logic [DELAY_BITS-1:0] delay;
    logic [EVENT_BITS-1:0] event_id;
  } req_t;

  typedef struct packed {
    kind_e                 kind;
    logic [EVENT_BITS-1:0] fired_event;
    logic                  last;
    logic [OCC_W-1:0]      pending;
  } rsp_t;

  typedef struct packed {
    cell_mode_e       mode;
    logic [OCC_W-1:0] occ;
  } cell_ctrl_t;

  // Entry traveling down the chain during an insert
  typedef struct packed {
    logic                  valid;
    logic                  placed;
    logic [DELAY_BITS-1:0] delta;
    logic [EVENT_BITS-1:0] ev;
  } tok_t;

endpackage

`default_nettype wire

### design/dtq_cell.sv
`default_nettype none

module dtq_cell (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [dtq_pkg::IDX_W-1:0]       idx_i,
  input  wire dtq_pkg::cell_ctrl_t             ctrl_i,
  input  wire dtq_pkg::tok_t                   tok_i,
  output dtq_pkg::tok_t                        tok_o,
  input  wire logic [dtq_pkg::DELAY_BITS-1:0]  nxt_delta_i,
  input  wire logic [dtq_pkg::EVENT_BITS-1:0]  nxt_ev_i,
  output logic [dtq_pkg::DELAY_BITS-1:0]       delta_o,
  output logic [dtq_pkg::EVENT_BITS-1:0]       ev_o
);

  logic [dtq_pkg::DELAY_BITS-1:0] delta_q, delta_d;
  logic [dtq_pkg::EVENT_BITS-1:0] ev_q, ev_d;
  dtq_pkg::tok_t                  tok_q, tok_d;
  logic                           occupied;
  logic                           is_head;

  assign occupied = dtq_pkg::OCC_W'(idx_i) < ctrl_i.occ;
  assign is_head  = idx_i == '0;

  // Entry update and token hand-off
  always_comb begin
    delta_d = delta_q;
    ev_d    = ev_q;
    tok_d   = '0;
    case (ctrl_i.mode)
      dtq_pkg::CELL_DEC: begin
        if (is_head && delta_q != '0) begin
          delta_d = delta_q - 1'b1;
        end
      end
      dtq_pkg::CELL_SHIFT: begin
        delta_d = nxt_delta_i;
        ev_d    = nxt_ev_i;
      end
      dtq_pkg::CELL_INSERT: begin
        if (tok_i.valid) begin
          if (!occupied) begin
            // first free slot: token comes to rest here
            delta_d = tok_i.delta;
            ev_d    = tok_i.ev;
          end else if (tok_i.placed) begin
            // ripple: swap in the displaced entry, pass ours on
            delta_d = tok_i.delta;
            ev_d    = tok_i.ev;
            tok_d   = '{valid: 1'b1, placed: 1'b1, delta: delta_q, ev: ev_q};
          end else if (tok_i.delta >= delta_q) begin
            // deadline at or past ours: walk on with the remainder
            tok_d       = tok_i;
            tok_d.delta = tok_i.delta - delta_q;
          end else begin
            // new entry goes here, our entry keeps only the difference
            delta_d = tok_i.delta;
            ev_d    = tok_i.ev;
            tok_d   = '{valid: 1'b1, placed: 1'b1, delta: delta_q - tok_i.delta, ev: ev_q};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    ev_q    <= ev_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o   = tok_q;
  assign delta_o = delta_q;
  assign ev_o    = ev_q;

endmodule

`default_nettype wire

### design/delta_timer_queue_top.sv
`default_nettype none
// Delta-list timer queue built as a chain of entry cells, head at cell 0.
// Insert: busy while the new entry walks the chain one cell a cycle, up to the tail;
//   the acknowledge appears in the cycle after the last walk step. A full queue answers next cycle.
// Tick: busy while the head is decremented and then the expiries pop, one expiry per cycle; empty queue: no busy.
// Results are registered and shown for one cycle; the receiver cannot stall.
// Reset (async, active low) empties the queue and returns to idle; entries need no clearing.

module delta_timer_queue_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire dtq_pkg::req_t  req_i,
  output logic                busy_o,
  output logic                rsp_valid_o,
  output dtq_pkg::rsp_t       rsp_o
);

  localparam int CAP = dtq_pkg::CAPACITY;

  dtq_pkg::state_e                state_q, state_d;
  logic [dtq_pkg::OCC_W-1:0]      occ_q, occ_d;
  logic [dtq_pkg::OCC_W-1:0]      step_q, step_d;
  dtq_pkg::tok_t                  inj_q, inj_d;
  logic                           rsp_valid_q, rsp_valid_d;
  dtq_pkg::rsp_t                  rsp_q, rsp_d;
  dtq_pkg::cell_ctrl_t            ctrl;

  dtq_pkg::tok_t                  tok [CAP+1];
  logic [dtq_pkg::DELAY_BITS-1:0] cell_delta [CAP+1];
  logic [dtq_pkg::EVENT_BITS-1:0] cell_ev [CAP+1];

  logic accept;
  logic full;
  logic head_zero;
  logic pop_last;

  assign accept    = start_i && (state_q == dtq_pkg::ST_IDLE);
  assign full      = occ_q == dtq_pkg::OCC_W'(CAP);
  assign head_zero = cell_delta[0] == '0;
  assign pop_last  = (occ_q == dtq_pkg::OCC_W'(1)) || (cell_delta[1] != '0);

  // Cell chain
  assign tok[0]          = inj_q;
  assign cell_delta[CAP] = '0;
  assign cell_ev[CAP]    = '0;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    dtq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (dtq_pkg::IDX_W'(i)),
      .ctrl_i      (ctrl),
      .tok_i       (tok[i]),
      .tok_o       (tok[i+1]),
      .nxt_delta_i (cell_delta[i+1]),
      .nxt_ev_i    (cell_ev[i+1]),
      .delta_o     (cell_delta[i]),
      .ev_o        (cell_ev[i])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dtq_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_i.op == dtq_pkg::OP_INSERT && !full) begin
            state_d = dtq_pkg::ST_INSERT;
          end else if (req_i.op == dtq_pkg::OP_TICK && occ_q != '0) begin
            state_d = dtq_pkg::ST_TICK;
          end
        end
      end
      dtq_pkg::ST_INSERT: begin
        if (step_q == occ_q) begin
          state_d = dtq_pkg::ST_IDLE;
        end
      end
      dtq_pkg::ST_TICK: begin
        state_d = dtq_pkg::ST_POP;
      end
      dtq_pkg::ST_POP: begin
        if (!head_zero || pop_last) begin
          state_d = dtq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dtq_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs, cell control and datapath updates
  always_comb begin
    occ_d        = occ_q;
    step_d       = step_q;
    inj_d        = '0;
    rsp_valid_d  = 1'b0;
    rsp_d        = rsp_q;
    ctrl.mode    = dtq_pkg::CELL_HOLD;
    ctrl.occ     = occ_q;
    case (state_q)
      dtq_pkg::ST_IDLE: begin
        step_d = '0;
        if (accept && req_i.op == dtq_pkg::OP_INSERT) begin
          if (full) begin
            rsp_valid_d = 1'b1;
            rsp_d = '{kind: dtq_pkg::KIND_FULL, fired_event: '0, last: 1'b1, pending: occ_q};
          end else begin
            // zero delay fires on the next tick
            inj_d.valid  = 1'b1;
            inj_d.placed = 1'b0;
            inj_d.delta  = (req_i.delay == '0) ? dtq_pkg::DELAY_BITS'(1) : req_i.delay;
            inj_d.ev     = req_i.event_id;
          end
        end
      end
      dtq_pkg::ST_INSERT: begin
        ctrl.mode = dtq_pkg::CELL_INSERT;
        step_d    = step_q + 1'b1;
        if (step_q == occ_q) begin
          occ_d       = occ_q + 1'b1;
          rsp_valid_d = 1'b1;
          rsp_d = '{kind: dtq_pkg::KIND_ACK, fired_event: '0, last: 1'b1,
                    pending: occ_q + 1'b1};
        end
      end
      dtq_pkg::ST_TICK: begin
        ctrl.mode = dtq_pkg::CELL_DEC;
      end
      dtq_pkg::ST_POP: begin
        if (head_zero) begin
          ctrl.mode   = dtq_pkg::CELL_SHIFT;
          occ_d       = occ_q - 1'b1;
          rsp_valid_d = 1'b1;
          rsp_d = '{kind: dtq_pkg::KIND_EXPIRED, fired_event: cell_ev[0], last: pop_last,
                    pending: occ_q - 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtq_pkg::ST_IDLE;
      occ_q       <= '0;
      step_q      <= '0;
      inj_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      step_q      <= step_d;
      inj_q       <= inj_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign busy_o      = state_q != dtq_pkg::ST_IDLE;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Checks
  a_tok_absorbed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tok[CAP].valid)
    else $error("insert token ran off the end of the chain");

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= dtq_pkg::OCC_W'(CAP))
    else $error("occupancy above capacity");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dtq_pkg::ST_INSERT |-> step_q <= occ_q)
    else $error("insert walk passed the tail");

  a_expire_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_q.kind == dtq_pkg::KIND_EXPIRED |-> $past(state_q) == dtq_pkg::ST_POP)
    else $error("expiry reported outside pop phase");

endmodule

`default_nettype wire
